@@ design/sbiq_pkg.sv @@
// shared widths, reset values, register codes and types of the stereo biquad
package sbiq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int HIST_W    = 24;
  localparam int COEF_FRAC = 22;
  localparam int HIST_FRAC = 8;
  localparam int PROD_W    = COEF_W + SAMPLE_W;   // coef times sample
  localparam int FF_W      = PROD_W + 2;          // sum of three such products
  localparam int FB_W      = COEF_W + HIST_W;     // coef times held output
  localparam int ACC_W     = FF_W + HIST_FRAC + 2;
  localparam int QACC_W    = ACC_W - COEF_FRAC;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [COEF_W-1:0] B0_RESET = 24'sd954574;
  localparam logic signed [COEF_W-1:0] B1_RESET = -24'sd704914;
  localparam logic signed [COEF_W-1:0] B2_RESET = -24'sd171363;
  localparam logic signed [COEF_W-1:0] A1_RESET = 24'sd7197752;
  localparam logic signed [COEF_W-1:0] A2_RESET = -24'sd3011384;

  localparam logic signed [HIST_W-1:0] HIST_MAX = 24'sd8388607;
  localparam logic signed [HIST_W-1:0] HIST_MIN = -24'sd8388608;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
  } coef_t;

  typedef struct packed {
    logic ld_ff;    // feedforward stage takes a new frame
    logic ld_out;   // feedback stage produces a result
  } stage_ctrl_t;

endpackage

@@ design/sbiq_ifs.sv @@
// frame channels of the stereo biquad: input frames and filtered frames
interface sbiq_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [sbiq_pkg::SAMPLE_W-1:0]    left_in;
  logic signed [sbiq_pkg::SAMPLE_W-1:0]    right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sbiq_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [sbiq_pkg::SAMPLE_W-1:0]    left_out;
  logic signed [sbiq_pkg::SAMPLE_W-1:0]    right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

@@ design/stereo_biquad_inverse_riaa.sv @@
// top level of the stereo direct form i biquad with inverse riaa reset coefficients
//
// Filters each stereo frame of two signed 16-bit samples through the same
// second-order section on both channels:
//   y[n] = b0*x[n] + b1*x[n-1] + b2*x[n-2] + a1*y[n-1] + a2*y[n-2]
// coefficients are signed q2.22 and reset to the inverse riaa set; the held
// outputs keep 8 fraction bits, and the sample sent out is that value
// truncated toward zero. One frame is taken every cycle unless the output
// stalls; a result is presented from the result register after its frame
// has passed the feedforward register. The first stage forms the three
// feedforward products and their sum; the second adds the two feedback
// products of the held outputs, truncates toward zero and saturates, and
// fills the result register, so the loop through the output history closes
// within the feedback stage. A result waiting in the output register still
// lets one more frame into the feedforward stage; with both stages full the
// input stalls until the result transfers. Coefficients are written through the
// configuration port, index 0 to 4 for b0, b1, b2, a1, a2; other indexes are
// ignored. Write them only while no frame is in flight.
module stereo_biquad_inverse_riaa (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sbiq_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sbiq_pkg::COEF_W-1:0]        cfg_data_i,
  sbiq_in_if.sink                            in_i,
  sbiq_out_if.source                         out_o
);
  import sbiq_pkg::*;

  coef_t       coef;
  stage_ctrl_t ctrl;

  // valid flags of the feedforward stage and of the result register
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic in_ready;
  logic ld_ff;
  logic ld_out;

  // result register moves on when empty or when its transfer completes
  assign ld_out   = s1_valid_q && (!out_valid_q || out_o.ready);
  // feedforward stage frees up when empty or when it hands on its frame
  assign in_ready = !s1_valid_q || ld_out;
  assign ld_ff    = in_i.valid && in_ready;
  assign ctrl     = '{ld_ff: ld_ff, ld_out: ld_out};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (ld_ff) begin
      s1_valid_d = 1'b1;
    end else if (ld_out) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  sbiq_coef_regs u_coef_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coef_o     (coef)
  );

  // both channels step together, one history set each
  sbiq_channel u_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef),
    .ctrl_i (ctrl),
    .x_i    (in_i.left_in),
    .y_o    (out_o.left_out)
  );

  sbiq_channel u_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef),
    .ctrl_i (ctrl),
    .x_i    (in_i.right_in),
    .y_o    (out_o.right_out)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;

`ifndef SYNTHESIS
  // both stages full and the result stalled: no new frame may enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("frame accepted while both stages are full");

  // an accepted frame occupies the feedforward stage next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s1_valid_q)
    else $error("accepted frame lost from the feedforward stage");

  // a finished frame shows up as a valid result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_out |=> out_o.valid)
    else $error("result register did not present its frame");

  // a stalled result keeps the pending frame in the feedforward stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !out_o.ready) |=> s1_valid_q)
    else $error("pending frame dropped during output stall");
`endif

endmodule

@@ design/sbiq_coef_regs.sv @@
// coefficient register file with inverse riaa reset values
module sbiq_coef_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sbiq_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [sbiq_pkg::COEF_W-1:0]          cfg_data_i,
  output sbiq_pkg::coef_t                      coef_o
);
  import sbiq_pkg::*;

  coef_t coef_q, coef_d;

  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_B0:  coef_d.b0 = $signed(cfg_data_i);
        REG_B1:  coef_d.b1 = $signed(cfg_data_i);
        REG_B2:  coef_d.b2 = $signed(cfg_data_i);
        REG_A1:  coef_d.a1 = $signed(cfg_data_i);
        REG_A2:  coef_d.a2 = $signed(cfg_data_i);
        default: coef_d = coef_q;   // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= B0_RESET;
      coef_q.b1 <= B1_RESET;
      coef_q.b2 <= B2_RESET;
      coef_q.a1 <= A1_RESET;
      coef_q.a2 <= A2_RESET;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

@@ design/sbiq_channel.sv @@
// one channel of the direct form i biquad: feedforward stage, then feedback stage
module sbiq_channel (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sbiq_pkg::coef_t                      coef_i,
  input  sbiq_pkg::stage_ctrl_t                ctrl_i,
  input  logic signed [sbiq_pkg::SAMPLE_W-1:0] x_i,
  output logic signed [sbiq_pkg::SAMPLE_W-1:0] y_o
);
  import sbiq_pkg::*;

  // input history, [0] one frame back
  logic signed [SAMPLE_W-1:0] xh0_q, xh1_q;
  // output history in q16.8
  logic signed [HIST_W-1:0]   yh0_q, yh1_q;
  logic signed [FF_W-1:0]     ff_q, ff_d;
  logic signed [SAMPLE_W-1:0] y_q, y_d;

  logic signed [PROD_W-1:0]   p0, p1, p2;
  logic signed [FB_W-1:0]     q1, q2;
  logic signed [ACC_W-1:0]    acc, acc_bias;
  logic signed [QACC_W-1:0]   acc_int;
  logic signed [HIST_W-1:0]   y_hist, y_bias;

  // feedforward part, does not depend on the feedback loop
  always_comb begin
    p0   = PROD_W'($signed(coef_i.b0) * x_i);
    p1   = PROD_W'($signed(coef_i.b1) * xh0_q);
    p2   = PROD_W'($signed(coef_i.b2) * xh1_q);
    ff_d = FF_W'(p0) + FF_W'(p1) + FF_W'(p2);
  end

  // feedback part: one add of the two feedback products onto the aligned sum
  always_comb begin
    q1       = FB_W'($signed(coef_i.a1) * yh0_q);
    q2       = FB_W'($signed(coef_i.a2) * yh1_q);
    acc      = ACC_W'($signed({ff_q, {HIST_FRAC{1'b0}}})) + ACC_W'(q1) + ACC_W'(q2);
    // round toward zero: bias negative sums before the arithmetic shift
    acc_bias = acc + (acc[ACC_W-1] ? ACC_W'((64'd1 << COEF_FRAC) - 64'd1) : '0);
    acc_int  = acc_bias[ACC_W-1:COEF_FRAC];
    if (acc_int > QACC_W'(HIST_MAX)) begin
      y_hist = HIST_MAX;
    end else if (acc_int < QACC_W'(HIST_MIN)) begin
      y_hist = HIST_MIN;
    end else begin
      y_hist = acc_int[HIST_W-1:0];
    end
    // integer part toward zero, always within the sample range
    y_bias = y_hist + (y_hist[HIST_W-1] ? HIST_W'((32'd1 << HIST_FRAC) - 32'd1) : '0);
    y_d    = y_bias[HIST_W-1:HIST_FRAC];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xh0_q <= '0;
      xh1_q <= '0;
      yh0_q <= '0;
      yh1_q <= '0;
    end else begin
      if (ctrl_i.ld_ff) begin
        xh1_q <= xh0_q;
        xh0_q <= x_i;
      end
      if (ctrl_i.ld_out) begin
        yh1_q <= yh0_q;
        yh0_q <= y_hist;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_ff) begin
      ff_q <= ff_d;
    end
    if (ctrl_i.ld_out) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule
